// File: sv/tkpq_pkg.sv
// package for the two-key sorted priority queue
// holds key widths, action and status codes, payload and cell control types
`default_nettype none

package tkpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CLASS_W     = 8;
    localparam int CODE_W      = 16;
    localparam int KEY_W       = CLASS_W + CODE_W;
    localparam int OCC_W       = 5;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_PRIO   = 2'd1,
        ACT_APPEND = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        action_t             action;
        logic [CLASS_W-1:0]  in_class;
        logic [CODE_W-1:0]   in_code;
    } req_item_t;

    typedef struct packed {
        logic                out_valid;
        logic [CLASS_W-1:0]  out_class;
        logic [CODE_W-1:0]   out_code;
        logic [OCC_W-1:0]    occupancy;
        logic                is_empty;
        status_t             status;
    } rsp_item_t;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic              ins;   // insert taken, queue not full
        logic              prio;  // sorted placement instead of tail
        logic              rem;   // remove taken, queue not empty
        logic [KEY_W-1:0]  key;   // key being inserted
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/tkpq_chan_if.sv
// valid/ready channels for requests and results of the queue
// depends on tkpq_pkg for the payload types
`default_nettype none

interface tkpq_req_if;
    logic                 valid;
    logic                 ready;
    tkpq_pkg::req_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tkpq_rsp_if;
    logic                 valid;
    logic                 ready;
    tkpq_pkg::rsp_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/tkpq_cell.sv
// one slot of the sorted queue row: holds a key, compares it with the
// incoming key and takes a neighbor's key on a shift; depends on tkpq_pkg
`default_nettype none

module tkpq_cell #(
    parameter int QUEUE_DEPTH = tkpq_pkg::QUEUE_DEPTH,
    parameter int INDEX       = 0
) (
    input  wire logic                               clk,
    input  wire tkpq_pkg::cell_ctrl_t               ctrl,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
    input  wire logic [tkpq_pkg::KEY_W-1:0]         left_key,
    input  wire logic [tkpq_pkg::KEY_W-1:0]         right_key,
    input  wire logic                               found_in,
    output logic                                    found_out,
    output logic [tkpq_pkg::KEY_W-1:0]              key
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [tkpq_pkg::KEY_W-1:0] key_reg;
    logic [tkpq_pkg::KEY_W-1:0] key_next;
    logic                       held;
    logic                       gt;

    assign held      = MY_IDX < count;
    assign gt        = ctrl.prio && held && (key_reg > ctrl.key);
    assign found_out = found_in || gt;
    assign key       = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins)
        begin
            // cells past the insertion point move one place toward the tail
            if (found_in)
            begin
                key_next = left_key;
            end
            else if (gt || (count == MY_IDX))
            begin
                key_next = ctrl.key;
            end
        end
        else if (ctrl.rem)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

// File: sv/two_key_sorted_priority_queue_top.sv
// top level of the two-key sorted priority queue: request/result channels,
// entry count and the row of tkpq_cell slots; depends on tkpq_pkg, tkpq_chan_if
`default_nettype none

// Sorted queue of up to QUEUE_DEPTH entries, each a class (8 bits) and code
// (16 bits). Every request gives exactly one result with the count after it,
// an empty flag and a status. A priority insert lands before the first held
// entry, from the head, whose class/code key is greater; an append lands at
// the tail; a remove returns the head. For each request all slots compare
// the new key with their own at once and the row shifts at the edge that
// takes it, and the result sits in an output register, so a new request
// is taken every cycle as long as the result side keeps up. No clearing
// after reset: the queue is empty and usable at once.
module two_key_sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = tkpq_pkg::QUEUE_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tkpq_req_if.sink   request,
    tkpq_rsp_if.source result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    tkpq_pkg::rsp_item_t         rsp_reg;
    tkpq_pkg::rsp_item_t         rsp_next;
    tkpq_pkg::cell_ctrl_t        ctrl;
    tkpq_pkg::status_t           status;
    logic                        accept;
    logic                        is_full;
    logic                        is_none;
    logic [tkpq_pkg::KEY_W-1:0]  cell_key [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]        found;

    assign request.ready = !rsp_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;
    assign is_full       = count_reg == FULL_CNT;
    assign is_none       = count_reg == '0;

    always_comb
    begin
        ctrl.ins   = 1'b0;
        ctrl.prio  = 1'b0;
        ctrl.rem   = 1'b0;
        ctrl.key   = {request.payload.in_class, request.payload.in_code};
        status     = tkpq_pkg::ST_OK;
        count_next = count_reg;
        unique case (request.payload.action)
            tkpq_pkg::ACT_PRIO, tkpq_pkg::ACT_APPEND:
            begin
                if (is_full)
                begin
                    status = tkpq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.ins   = accept;
                    ctrl.prio  = request.payload.action == tkpq_pkg::ACT_PRIO;
                    count_next = count_reg + 1'b1;
                end
            end
            tkpq_pkg::ACT_REMOVE:
            begin
                if (is_none)
                begin
                    status = tkpq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.rem   = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign found[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [tkpq_pkg::KEY_W-1:0] left_key;
        logic [tkpq_pkg::KEY_W-1:0] right_key;

        if (i == 0)
        begin : g_head
            assign left_key = ctrl.key;
        end
        else
        begin : g_body
            assign left_key = cell_key[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_key = cell_key[i];
        end
        else
        begin : g_next
            assign right_key = cell_key[i+1];
        end

        tkpq_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .INDEX       (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .left_key  (left_key),
            .right_key (right_key),
            .found_in  (found[i]),
            .found_out (found[i+1]),
            .key       (cell_key[i])
        );
    end

    always_comb
    begin
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg;
        if (result.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.out_valid = ctrl.rem;
            rsp_next.out_class = ctrl.rem ? cell_key[0][tkpq_pkg::KEY_W-1:tkpq_pkg::CODE_W]
                                          : '0;
            rsp_next.out_code  = ctrl.rem ? cell_key[0][tkpq_pkg::CODE_W-1:0] : '0;
            rsp_next.occupancy = tkpq_pkg::OCC_W'(count_next);
            rsp_next.is_empty  = count_next == '0;
            rsp_next.status    = status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign result.valid   = rsp_valid_reg;
    assign result.payload = rsp_reg;

endmodule

`default_nettype wire
